FILE: src/srp_pkg.sv
// Shared types and constants of the staircase rectangle placer.
package srp_pkg;

   localparam int COORD_W = 32;
   localparam int SIZE_W = 24;
   localparam int INDEX_W = 7;
   localparam int WIN_W = 16;
   localparam int AREA_W = 64;
   localparam int SCORE_W = 18;

   localparam int DIV_NUM_W = 97;
   localparam int DIV_DEN_W = 80;
   localparam int DIV_QUO_W = 21;
   localparam int DIV_STEP_W = 5;
   localparam logic [DIV_QUO_W-1:0] AREA_CAP = 21'd1048576;

   localparam logic [WIN_W-1:0] WINDOW_WIDTH_RESET = 16'd640;
   localparam logic [WIN_W-1:0] WINDOW_HEIGHT_RESET = 16'd480;

   localparam logic REG_WINDOW_WIDTH = 1'b0;
   localparam logic REG_WINDOW_HEIGHT = 1'b1;

   localparam logic OP_PLACE = 1'b0;
   localparam logic OP_NEWLINE = 1'b1;

   localparam int ORDER_WEIGHT_DIV = 50;
   localparam logic signed [23:0] SCORE_ONE = 24'sd65536;
   localparam logic signed [23:0] SCORE_MAX = 24'sd131071;
   localparam logic signed [23:0] SCORE_MIN = -24'sd131072;

   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_PUSH = 2'd1,
      CELL_POP  = 2'd2
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type       cmd;
      logic [COORD_W-1:0] top_x;
      logic [COORD_W-1:0] top_y;
   } stack_ctl_type;

endpackage

FILE: src/srp_cell.sv
// One corner cell of a stack chain: hold, take from the upper or the lower neighbour.
module srp_cell (
   input  logic                        clock,
   input  srp_pkg::cell_cmd_type       cmd,
   input  logic [srp_pkg::COORD_W-1:0] up_x,
   input  logic [srp_pkg::COORD_W-1:0] up_y,
   input  logic [srp_pkg::COORD_W-1:0] down_x,
   input  logic [srp_pkg::COORD_W-1:0] down_y,
   output logic [srp_pkg::COORD_W-1:0] x,
   output logic [srp_pkg::COORD_W-1:0] y
);

   logic [srp_pkg::COORD_W-1:0] x_ff, y_ff, x_in, y_in;

   always_comb begin
      unique case (cmd)
         srp_pkg::CELL_PUSH: begin
            x_in = up_x;
            y_in = up_y;
         end
         srp_pkg::CELL_POP: begin
            x_in = down_x;
            y_in = down_y;
         end
         default: begin
            x_in = x_ff;
            y_in = y_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign x = x_ff;
   assign y = y_ff;

endmodule

FILE: src/srp_stack.sv
// Stack of corners built as a chain of cells; the top two entries are visible.
module srp_stack #(
   parameter int DEPTH = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  srp_pkg::stack_ctl_type      ctl,
   output logic [srp_pkg::COORD_W-1:0] top0_x,
   output logic [srp_pkg::COORD_W-1:0] top0_y,
   output logic [srp_pkg::COORD_W-1:0] top1_x,
   output logic [srp_pkg::COORD_W-1:0] top1_y
);

   logic [srp_pkg::COORD_W-1:0] x_q [DEPTH];
   logic [srp_pkg::COORD_W-1:0] y_q [DEPTH];
   logic [srp_pkg::COORD_W-1:0] top_x_ff, top_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_x_ff <= '0;
         top_y_ff <= '0;
      end else begin
         top_x_ff <= ctl.top_x;
         top_y_ff <= ctl.top_y;
      end
   end

   assign x_q[0] = top_x_ff;
   assign y_q[0] = top_y_ff;

   for (genvar j = 1; j < DEPTH; j++) begin : g_cell
      if (j == DEPTH - 1) begin : g_end
         srp_cell u_cell (
            .clock  (clock),
            .cmd    (ctl.cmd),
            .up_x   (x_q[j-1]),
            .up_y   (y_q[j-1]),
            .down_x (x_q[j]),
            .down_y (y_q[j]),
            .x      (x_q[j]),
            .y      (y_q[j])
         );
      end else begin : g_mid
         srp_cell u_cell (
            .clock  (clock),
            .cmd    (ctl.cmd),
            .up_x   (x_q[j-1]),
            .up_y   (y_q[j-1]),
            .down_x (x_q[j+1]),
            .down_y (y_q[j+1]),
            .x      (x_q[j]),
            .y      (y_q[j])
         );
      end
   end

   assign top0_x = x_q[0];
   assign top0_y = y_q[0];
   assign top1_x = x_q[1];
   assign top1_y = y_q[1];

endmodule

FILE: src/srp_divider.sv
// Restoring divider, one quotient bit a cycle, quotient capped.
module srp_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [srp_pkg::DIV_NUM_W-1:0] num_in,
   input  logic [srp_pkg::DIV_DEN_W-1:0] den_in,
   output logic                          done,
   output logic [srp_pkg::DIV_QUO_W-1:0] quo
);

   localparam int DSH_W = srp_pkg::DIV_DEN_W + srp_pkg::DIV_QUO_W;

   logic                            run_ff, run_in, done_ff, done_in;
   logic [srp_pkg::DIV_STEP_W-1:0]  step_ff, step_in;
   logic [srp_pkg::DIV_NUM_W-1:0]   rem_ff, rem_in;
   logic [DSH_W-1:0]                dsh_ff, dsh_in;
   logic [srp_pkg::DIV_QUO_W-1:0]   q_ff, q_in;
   logic [DSH_W-1:0]                num_ext, rem_ext;

   assign num_ext = DSH_W'(num_in);
   assign rem_ext = DSH_W'(rem_ff);

   always_comb begin
      run_in = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in = q_ff;
      if (start) begin
         if (num_ext >= {den_in, {srp_pkg::DIV_QUO_W{1'b0}}}) begin
            q_in = srp_pkg::AREA_CAP;
            done_in = 1'b1;
            run_in = 1'b0;
         end else begin
            rem_in = num_in;
            dsh_in = {1'b0, den_in, {(srp_pkg::DIV_QUO_W-1){1'b0}}};
            q_in = '0;
            step_in = srp_pkg::DIV_STEP_W'(srp_pkg::DIV_QUO_W - 1);
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         if (rem_ext >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff[srp_pkg::DIV_NUM_W-1:0];
            q_in = {q_ff[srp_pkg::DIV_QUO_W-2:0], 1'b1};
         end else begin
            q_in = {q_ff[srp_pkg::DIV_QUO_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         if (step_ff == '0) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff <= q_in;
   end

   assign done = done_ff;
   assign quo = (q_ff > srp_pkg::AREA_CAP) ? srp_pkg::AREA_CAP : q_ff;

endmodule

FILE: src/staircase_rectangle_placer_top.sv
// Top level of the staircase rectangle placer: sequencer, corner stacks, scoring.
//
// Requests arrive on req_* under req_valid / req_stall: a rectangle (op 0) or a
// newline (op 1), with last marking the final item of an order. Each request gives
// one response on rsp_* under rsp_valid / rsp_stall: the placed lower-left corner,
// and on the last item the score or the error flag.
// The corner list sits in two chains of cells, the corners left of the focus and
// those from the focus on, so the focus moves by handing a corner across and every
// insert or merge is one push or pop of a whole chain.
// Steps: a request is taken in the idle state and worked in the place state; a placed
// rectangle then merges corners in the back and forward states; every request ends in
// the finish state, which loads the response register. A last item adds the score:
// products, the area division (skipped when an extent or a window register is zero)
// and the order division (skipped for a one-item order).
// One request is worked on at a time; the next is taken once the previous one has
// reached the response register, even while that result is stalled.
// Reset, synchronous and active high, empties the corner list to one corner at the
// origin, clears the order state and sets the window registers to 640 by 480.
// While rsp_stall is high the response holds and a finished request waits.
module staircase_rectangle_placer_top #(
   parameter int CORNER_DEPTH = 256,
   parameter int ORDER_LENGTH_MAX = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_op,
   input  logic [srp_pkg::SIZE_W-1:0]         req_rect_width,
   input  logic [srp_pkg::SIZE_W-1:0]         req_rect_height,
   input  logic [srp_pkg::INDEX_W-1:0]        req_rect_index,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [srp_pkg::COORD_W-1:0]        rsp_pos_x,
   output logic [srp_pkg::COORD_W-1:0]        rsp_pos_y,
   output logic                               rsp_placed,
   output logic signed [srp_pkg::SCORE_W-1:0] rsp_score,
   output logic                               rsp_score_valid,
   output logic                               rsp_score_error,
   input  logic                               csr_write_enable,
   input  logic                               csr_index,
   input  logic [srp_pkg::WIN_W-1:0]          csr_write_data
);

   localparam int CW = $clog2(CORNER_DEPTH + 1);
   localparam int NW = $clog2(ORDER_LENGTH_MAX + 1);
   localparam int TDEN_W = 2 * NW + 6;
   localparam int XW = srp_pkg::COORD_W;

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_PLACE = 13'b0000000000010,
      ST_BACK  = 13'b0000000000100,
      ST_FWD   = 13'b0000000001000,
      ST_SC0   = 13'b0000000010000,
      ST_SC1   = 13'b0000000100000,
      ST_SC2   = 13'b0000001000000,
      ST_SC3   = 13'b0000010000000,
      ST_DIVA  = 13'b0000100000000,
      ST_TST   = 13'b0001000000000,
      ST_DIVT  = 13'b0010000000000,
      ST_SCF   = 13'b0100000000000,
      ST_FIN   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic                          op_ff, op_in, last_ff, last_in;
   logic [srp_pkg::SIZE_W-1:0]    w_ff, w_in, h_ff, h_in;
   logic [srp_pkg::INDEX_W-1:0]   idx_ff, idx_in;
   logic [XW-1:0]                 xnew_ff, xnew_in, ynew_ff, ynew_in;
   logic [XW-1:0]                 px_ff, px_in, py_ff, py_in;
   logic                          placed_ff, placed_in;
   logic [CW-1:0]                 lc_ff, lc_in, rc_ff, rc_in;
   logic [XW-1:0]                 xext_ff, xext_in, yext_ff, yext_in;
   logic [srp_pkg::AREA_W-1:0]    area_ff, area_in;
   logic [srp_pkg::INDEX_W-1:0]   first_ff, first_in, prev_ff, prev_in;
   logic                          seen_ff, seen_in;
   logic [NW-1:0]                 cnt_ff, cnt_in;
   logic [srp_pkg::WIN_W-1:0]     win_w_ff, win_w_in, win_h_ff, win_h_in;

   logic [47:0]                   wy_ff, wy_in, hx_ff, hx_in;
   logic                          fzero_ff, fzero_in;
   logic [63:0]                   ee_ff, ee_in;
   logic [79:0]                   nm_ff, nm_in, den_ff, den_in;
   logic [srp_pkg::WIN_W-1:0]     o_ff, o_in;
   logic [2*NW-1:0]               nn_ff, nn_in;
   logic [TDEN_W-1:0]             tden_ff, tden_in;
   logic [srp_pkg::DIV_QUO_W-1:0] f_ff, f_in, t_ff, t_in;
   logic signed [srp_pkg::SCORE_W-1:0] score_ff, score_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [XW-1:0]                 rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                          rsp_placed_ff, rsp_placed_in;
   logic signed [srp_pkg::SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic                          rsp_sv_ff, rsp_sv_in, rsp_se_ff, rsp_se_in;

   srp_pkg::stack_ctl_type        l_ctl, r_ctl;
   logic [XW-1:0]                 l0x, l0y, l1x, l1y, r0x, r0y, r1x, r1y;

   logic [XW:0]                   sum_x, sum_y;
   logic [XW-1:0]                 xnew_c, ynew_c;
   logic                          ins_c, full_c;
   logic [47:0]                   wh_c;
   logic [srp_pkg::AREA_W:0]      area_sum;
   logic signed [7:0]             diff_c;
   logic [6:0]                    mag_c;
   logic [TDEN_W:0]               tnum_c;
   logic [2*NW-2:0]               half_nn;

   logic                          div_start, div_done;
   logic [srp_pkg::DIV_NUM_W-1:0] div_num;
   logic [srp_pkg::DIV_DEN_W-1:0] div_den;
   logic [srp_pkg::DIV_QUO_W-1:0] div_quo;
   logic signed [23:0]            t_signed, s_c;
   logic                          out_free;

   srp_stack #(.DEPTH(CORNER_DEPTH)) u_left (
      .clock(clock), .reset(reset), .ctl(l_ctl),
      .top0_x(l0x), .top0_y(l0y), .top1_x(l1x), .top1_y(l1y)
   );

   srp_stack #(.DEPTH(CORNER_DEPTH)) u_right (
      .clock(clock), .reset(reset), .ctl(r_ctl),
      .top0_x(r0x), .top0_y(r0y), .top1_x(r1x), .top1_y(r1y)
   );

   srp_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num_in(div_num), .den_in(div_den), .done(div_done), .quo(div_quo)
   );

   assign sum_x = {1'b0, r0x} + {{(XW+1-srp_pkg::SIZE_W){1'b0}}, w_ff};
   assign sum_y = {1'b0, r0y} + {{(XW+1-srp_pkg::SIZE_W){1'b0}}, h_ff};
   assign xnew_c = sum_x[XW] ? '1 : sum_x[XW-1:0];
   assign ynew_c = sum_y[XW] ? '1 : sum_y[XW-1:0];
   assign ins_c = (lc_ff == '0) || (r0x == '0) || (ynew_c < l0y);
   assign full_c = ({1'b0, lc_ff} + {1'b0, rc_ff}) >= (CW+1)'(CORNER_DEPTH);
   assign wh_c = {24'b0, w_ff} * {24'b0, h_ff};
   assign area_sum = {1'b0, area_ff} + {17'b0, wh_c};

   assign diff_c = $signed({1'b0, first_ff}) - $signed({1'b0, prev_ff});
   assign mag_c = diff_c[7] ? 7'(-diff_c) : diff_c[6:0];
   assign tnum_c = (TDEN_W+1)'({mag_c, 16'b0}) + {1'b0, (tden_ff >> 1)};
   assign half_nn = nn_ff[2*NW-1:1];

   assign div_start = (state_ff == ST_SC3 && !fzero_ff) ||
                      (state_ff == ST_TST && tden_ff != '0);
   assign div_num = (state_ff == ST_SC3)
                  ? ({1'b0, nm_ff, 16'b0} + srp_pkg::DIV_NUM_W'(den_ff[79:1]))
                  : srp_pkg::DIV_NUM_W'(tnum_c);
   assign div_den = (state_ff == ST_SC3) ? den_ff : srp_pkg::DIV_DEN_W'(tden_ff);

   assign t_signed = diff_c[7] ? -$signed({3'b0, t_ff}) : $signed({3'b0, t_ff});
   assign s_c = srp_pkg::SCORE_ONE - $signed({3'b0, f_ff}) + t_signed;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      last_in = last_ff;
      w_in = w_ff;
      h_in = h_ff;
      idx_in = idx_ff;
      xnew_in = xnew_ff;
      ynew_in = ynew_ff;
      px_in = px_ff;
      py_in = py_ff;
      placed_in = placed_ff;
      lc_in = lc_ff;
      rc_in = rc_ff;
      xext_in = xext_ff;
      yext_in = yext_ff;
      area_in = area_ff;
      first_in = first_ff;
      prev_in = prev_ff;
      seen_in = seen_ff;
      cnt_in = cnt_ff;
      win_w_in = win_w_ff;
      win_h_in = win_h_ff;
      wy_in = wy_ff;
      hx_in = hx_ff;
      fzero_in = fzero_ff;
      ee_in = ee_ff;
      nm_in = nm_ff;
      den_in = den_ff;
      o_in = o_ff;
      nn_in = nn_ff;
      tden_in = tden_ff;
      f_in = f_ff;
      t_in = t_ff;
      score_in = score_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      rsp_placed_in = rsp_placed_ff;
      rsp_score_in = rsp_score_ff;
      rsp_sv_in = rsp_sv_ff;
      rsp_se_in = rsp_se_ff;
      l_ctl = '{cmd: srp_pkg::CELL_HOLD, top_x: l0x, top_y: l0y};
      r_ctl = '{cmd: srp_pkg::CELL_HOLD, top_x: r0x, top_y: r0y};

      if (csr_write_enable) begin
         unique case (csr_index)
            srp_pkg::REG_WINDOW_WIDTH:  win_w_in = csr_write_data;
            srp_pkg::REG_WINDOW_HEIGHT: win_h_in = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_op;
               w_in = req_rect_width;
               h_in = req_rect_height;
               idx_in = req_rect_index;
               last_in = req_last;
               if (cnt_ff < NW'(ORDER_LENGTH_MAX)) cnt_in = cnt_ff + 1'b1;
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            px_in = '0;
            py_in = '0;
            placed_in = 1'b0;
            state_in = (last_ff && seen_ff) ? ST_SC0 : ST_FIN;
            if (op_ff == srp_pkg::OP_NEWLINE) begin
               if (lc_ff != '0) begin
                  l_ctl = '{cmd: srp_pkg::CELL_POP, top_x: l1x, top_y: l1y};
                  r_ctl = '{cmd: srp_pkg::CELL_PUSH, top_x: l0x, top_y: l0y};
                  lc_in = lc_ff - 1'b1;
                  rc_in = rc_ff + 1'b1;
               end
            end else if (!(ins_c && full_c)) begin
               placed_in = 1'b1;
               px_in = r0x;
               py_in = r0y;
               xnew_in = xnew_c;
               ynew_in = ynew_c;
               area_in = area_sum[srp_pkg::AREA_W] ? '1 : area_sum[srp_pkg::AREA_W-1:0];
               if (xnew_c > xext_ff) xext_in = xnew_c;
               if (ynew_c > yext_ff) yext_in = ynew_c;
               if (!seen_ff) first_in = idx_ff;
               prev_in = idx_ff;
               seen_in = 1'b1;
               r_ctl = '{cmd: srp_pkg::CELL_HOLD, top_x: xnew_c, top_y: r0y};
               if (ins_c) begin
                  l_ctl = '{cmd: srp_pkg::CELL_PUSH, top_x: r0x, top_y: ynew_c};
                  lc_in = lc_ff + 1'b1;
                  state_in = ST_FWD;
               end else begin
                  l_ctl = '{cmd: srp_pkg::CELL_HOLD, top_x: l0x, top_y: ynew_c};
                  state_in = ST_BACK;
               end
            end
         end
         ST_BACK: begin
            if (lc_ff >= CW'(2) && ynew_ff >= l1y) begin
               l_ctl = '{cmd: srp_pkg::CELL_POP, top_x: l1x, top_y: ynew_ff};
               lc_in = lc_ff - 1'b1;
            end else begin
               state_in = ST_FWD;
            end
         end
         ST_FWD: begin
            if (rc_ff >= CW'(2) && xnew_ff >= r1x) begin
               r_ctl = '{cmd: srp_pkg::CELL_POP, top_x: xnew_ff, top_y: r1y};
               rc_in = rc_ff - 1'b1;
            end else begin
               state_in = (last_ff && seen_ff) ? ST_SC0 : ST_FIN;
            end
         end
         ST_SC0: begin
            wy_in = {32'b0, win_w_ff} * {16'b0, yext_ff};
            hx_in = {32'b0, win_h_ff} * {16'b0, xext_ff};
            fzero_in = (xext_ff == '0) || (yext_ff == '0) ||
                       (win_w_ff == '0) || (win_h_ff == '0);
            nn_in = {{NW{1'b0}}, cnt_ff} * {{NW{1'b0}}, cnt_ff};
            state_in = ST_SC1;
         end
         ST_SC1: begin
            if (wy_ff < hx_ff) begin
               ee_in = {32'b0, xext_ff} * {32'b0, xext_ff};
               nm_in = {16'b0, area_ff} * {64'b0, win_w_ff};
               o_in = win_h_ff;
            end else begin
               ee_in = {32'b0, yext_ff} * {32'b0, yext_ff};
               nm_in = {16'b0, area_ff} * {64'b0, win_h_ff};
               o_in = win_w_ff;
            end
            tden_in = TDEN_W'(half_nn) * TDEN_W'(srp_pkg::ORDER_WEIGHT_DIV);
            state_in = ST_SC2;
         end
         ST_SC2: begin
            den_in = {16'b0, ee_ff} * {64'b0, o_ff};
            state_in = ST_SC3;
         end
         ST_SC3: begin
            f_in = '0;
            state_in = fzero_ff ? ST_TST : ST_DIVA;
         end
         ST_DIVA: begin
            if (div_done) begin
               f_in = div_quo;
               state_in = ST_TST;
            end
         end
         ST_TST: begin
            t_in = '0;
            state_in = (tden_ff != '0) ? ST_DIVT : ST_SCF;
         end
         ST_DIVT: begin
            if (div_done) begin
               t_in = div_quo;
               state_in = ST_SCF;
            end
         end
         ST_SCF: begin
            priority if (s_c > srp_pkg::SCORE_MAX) score_in = srp_pkg::SCORE_MAX[17:0];
            else if (s_c < srp_pkg::SCORE_MIN) score_in = srp_pkg::SCORE_MIN[17:0];
            else score_in = s_c[17:0];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in = px_ff;
               rsp_y_in = py_ff;
               rsp_placed_in = placed_ff;
               rsp_sv_in = last_ff && seen_ff;
               rsp_se_in = last_ff && !seen_ff;
               rsp_score_in = (last_ff && seen_ff) ? score_ff : '0;
               if (last_ff) begin
                  r_ctl = '{cmd: srp_pkg::CELL_HOLD, top_x: '0, top_y: '0};
                  lc_in = '0;
                  rc_in = CW'(1);
                  xext_in = '0;
                  yext_in = '0;
                  area_in = '0;
                  first_in = '0;
                  prev_in = '0;
                  seen_in = 1'b0;
                  cnt_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lc_ff <= '0;
         rc_ff <= CW'(1);
         xext_ff <= '0;
         yext_ff <= '0;
         area_ff <= '0;
         first_ff <= '0;
         prev_ff <= '0;
         seen_ff <= 1'b0;
         cnt_ff <= '0;
         win_w_ff <= srp_pkg::WINDOW_WIDTH_RESET;
         win_h_ff <= srp_pkg::WINDOW_HEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lc_ff <= lc_in;
         rc_ff <= rc_in;
         xext_ff <= xext_in;
         yext_ff <= yext_in;
         area_ff <= area_in;
         first_ff <= first_in;
         prev_ff <= prev_in;
         seen_ff <= seen_in;
         cnt_ff <= cnt_in;
         win_w_ff <= win_w_in;
         win_h_ff <= win_h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      last_ff <= last_in;
      w_ff <= w_in;
      h_ff <= h_in;
      idx_ff <= idx_in;
      xnew_ff <= xnew_in;
      ynew_ff <= ynew_in;
      px_ff <= px_in;
      py_ff <= py_in;
      placed_ff <= placed_in;
      wy_ff <= wy_in;
      hx_ff <= hx_in;
      fzero_ff <= fzero_in;
      ee_ff <= ee_in;
      nm_ff <= nm_in;
      den_ff <= den_in;
      o_ff <= o_in;
      nn_ff <= nn_in;
      tden_ff <= tden_in;
      f_ff <= f_in;
      t_ff <= t_in;
      score_ff <= score_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_placed_ff <= rsp_placed_in;
      rsp_score_ff <= rsp_score_in;
      rsp_sv_ff <= rsp_sv_in;
      rsp_se_ff <= rsp_se_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = rsp_x_ff;
   assign rsp_pos_y = rsp_y_ff;
   assign rsp_placed = rsp_placed_ff;
   assign rsp_score = rsp_score_ff;
   assign rsp_score_valid = rsp_sv_ff;
   assign rsp_score_error = rsp_se_ff;

endmodule

FILE: test/testbench.sv
// Self-checking testbench of the staircase rectangle placer with its own scoring model.
`timescale 1ns / 1ps

module testbench;
   import srp_pkg::*;

   localparam int CORNER_DEPTH = 256;
   localparam int ORDER_LENGTH_MAX = 256;
   localparam int QUIET_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 400;

   typedef struct packed {
      logic [COORD_W-1:0]        pos_x;
      logic [COORD_W-1:0]        pos_y;
      logic                      placed;
      logic signed [SCORE_W-1:0] score;
      logic                      score_valid;
      logic                      score_error;
   } placement_t;

   class placement_scoreboard;
      logic [COORD_W-1:0] corner_xs[CORNER_DEPTH];
      logic [COORD_W-1:0] corner_ys[CORNER_DEPTH];
      int unsigned corners;
      int unsigned focus;
      logic [COORD_W-1:0] x_reach;
      logic [COORD_W-1:0] y_reach;
      logic [AREA_W-1:0] filled_area;
      int first_index;
      int latest_index;
      bit rect_seen;
      int unsigned order_items;
      logic [WIN_W-1:0] win_w;
      logic [WIN_W-1:0] win_h;
      placement_t pending[$];
      int errors;
      int responses;

      function new();
         win_w = WINDOW_WIDTH_RESET;
         win_h = WINDOW_HEIGHT_RESET;
         errors = 0;
         responses = 0;
         clear_order();
      endfunction

      function void clear_order();
         for (int i = 0; i < CORNER_DEPTH; i++) begin
            corner_xs[i] = '0;
            corner_ys[i] = '0;
         end
         corners = 1;
         focus = 0;
         x_reach = '0;
         y_reach = '0;
         filled_area = '0;
         first_index = 0;
         latest_index = 0;
         rect_seen = 0;
         order_items = 0;
      endfunction

      function void set_window(logic idx, logic [WIN_W-1:0] value);
         if (idx == REG_WINDOW_WIDTH) begin
            win_w = value;
         end else begin
            win_h = value;
         end
      endfunction

      function logic [COORD_W-1:0] sat_add(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
         logic [COORD_W:0] s;
         s = a + b;
         return s[COORD_W] ? '1 : s[COORD_W-1:0];
      endfunction

      function bit place_rect(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                              logic [INDEX_W-1:0] idx,
                              output logic [COORD_W-1:0] px, output logic [COORD_W-1:0] py);
         int unsigned c;
         int unsigned cn;
         logic [COORD_W-1:0] x0;
         logic [COORD_W-1:0] y0;
         logic [COORD_W-1:0] xn;
         logic [COORD_W-1:0] yn;
         bit ins;
         logic [AREA_W:0] asum;
         c = focus;
         cn = corners;
         x0 = corner_xs[c];
         y0 = corner_ys[c];
         xn = sat_add(x0, {8'b0, w});
         yn = sat_add(y0, {8'b0, h});
         px = '0;
         py = '0;
         ins = (c == 0) || (x0 == 0);
         if (!ins) ins = (yn < corner_ys[c-1]);
         if (ins && cn >= CORNER_DEPTH) return 0;
         if (ins) begin
            for (int unsigned k = cn; k > c; k--) begin
               corner_xs[k] = corner_xs[k-1];
               corner_ys[k] = corner_ys[k-1];
            end
            cn++;
            corner_ys[c] = yn;
            c++;
         end else begin
            corner_ys[c-1] = yn;
            while (c >= 2 && yn >= corner_ys[c-2]) begin
               corner_ys[c-2] = corner_ys[c-1];
               for (int unsigned k = c - 1; k + 1 < cn; k++) begin
                  corner_xs[k] = corner_xs[k+1];
                  corner_ys[k] = corner_ys[k+1];
               end
               cn--;
               c--;
            end
         end
         corner_xs[c] = xn;
         while (c + 1 < cn && xn >= corner_xs[c+1]) begin
            corner_ys[c] = corner_ys[c+1];
            for (int unsigned k = c + 1; k + 1 < cn; k++) begin
               corner_xs[k] = corner_xs[k+1];
               corner_ys[k] = corner_ys[k+1];
            end
            cn--;
         end
         focus = c;
         corners = cn;
         asum = filled_area + 64'(w) * 64'(h);
         filled_area = asum[AREA_W] ? '1 : asum[AREA_W-1:0];
         if (xn > x_reach) x_reach = xn;
         if (yn > y_reach) y_reach = yn;
         if (!rect_seen) first_index = idx;
         latest_index = idx;
         rect_seen = 1;
         px = x0;
         py = y0;
         return 1;
      endfunction

      function logic [DIV_QUO_W-1:0] area_fraction();
         logic [47:0] wy;
         logic [47:0] hx;
         logic [127:0] num;
         logic [127:0] den;
         logic [127:0] q;
         logic [WIN_W-1:0] a_mul;
         logic [WIN_W-1:0] o;
         logic [COORD_W-1:0] e;
         if (x_reach == 0 || y_reach == 0 || win_w == 0 || win_h == 0) return '0;
         wy = win_w * y_reach;
         hx = win_h * x_reach;
         if (wy < hx) begin
            a_mul = win_w;
            e = x_reach;
            o = win_h;
         end else begin
            a_mul = win_h;
            e = y_reach;
            o = win_w;
         end
         num = 128'(filled_area) * a_mul;
         num = num << 16;
         den = 128'(e) * e * o;
         q = (num + (den >> 1)) / den;
         if (q > AREA_CAP) return AREA_CAP;
         return q[DIV_QUO_W-1:0];
      endfunction

      function longint order_drift();
         longint d;
         longint dv;
         longint mag;
         longint dn;
         longint q;
         d = longint'(first_index) - longint'(latest_index);
         dv = longint'(order_items) * longint'(order_items) / 2;
         if (dv == 0) return 0;
         mag = (d < 0 ? -d : d) * 65536;
         dn = ORDER_WEIGHT_DIV * dv;
         q = (mag + dn / 2) / dn;
         return d < 0 ? -q : q;
      endfunction

      function void note(logic op, logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                         logic [INDEX_W-1:0] idx, logic last);
         placement_t e;
         logic [COORD_W-1:0] px;
         logic [COORD_W-1:0] py;
         longint s;
         e = '0;
         if (order_items < ORDER_LENGTH_MAX) order_items++;
         if (op == OP_PLACE) begin
            e.placed = place_rect(w, h, idx, px, py);
            e.pos_x = px;
            e.pos_y = py;
         end else if (focus > 0) begin
            focus--;
         end
         if (last) begin
            if (rect_seen) begin
               s = longint'(SCORE_ONE) - longint'(area_fraction()) + order_drift();
               if (s > SCORE_MAX) s = SCORE_MAX;
               if (s < SCORE_MIN) s = SCORE_MIN;
               e.score = s[SCORE_W-1:0];
               e.score_valid = 1;
            end else begin
               e.score_error = 1;
            end
            clear_order();
         end
         pending.push_back(e);
      endfunction

      function void report(string what, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
         errors++;
         if (errors <= 10)
            $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
      endfunction

      function void check(placement_t got);
         placement_t e;
         responses++;
         if (pending.size() == 0) begin
            report("unexpected response", '0, got.pos_x);
            return;
         end
         e = pending.pop_front();
         if (got.pos_x !== e.pos_x) report("pos_x", e.pos_x, got.pos_x);
         if (got.pos_y !== e.pos_y) report("pos_y", e.pos_y, got.pos_y);
         if (got.placed !== e.placed) report("placed", e.placed, got.placed);
         if (got.score !== e.score) report("score", 32'(e.score), 32'(got.score));
         if (got.score_valid !== e.score_valid)
            report("score_valid", e.score_valid, got.score_valid);
         if (got.score_error !== e.score_error)
            report("score_error", e.score_error, got.score_error);
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_op = 0;
   logic [SIZE_W-1:0] req_rect_width = '0;
   logic [SIZE_W-1:0] req_rect_height = '0;
   logic [INDEX_W-1:0] req_rect_index = '0;
   logic req_last = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [COORD_W-1:0] rsp_pos_x;
   logic [COORD_W-1:0] rsp_pos_y;
   logic rsp_placed;
   logic signed [SCORE_W-1:0] rsp_score;
   logic rsp_score_valid;
   logic rsp_score_error;
   logic csr_write_enable = 0;
   logic csr_index = 0;
   logic [WIN_W-1:0] csr_write_data = '0;

   placement_scoreboard placements = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int requests_sent = 0;
   int orders_sent = 0;
   int quiet_cycles = 0;

   staircase_rectangle_placer_top #(
      .CORNER_DEPTH(CORNER_DEPTH),
      .ORDER_LENGTH_MAX(ORDER_LENGTH_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_rect_width(req_rect_width),
      .req_rect_height(req_rect_height),
      .req_rect_index(req_rect_index),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_placed(rsp_placed),
      .rsp_score(rsp_score),
      .rsp_score_valid(rsp_score_valid),
      .rsp_score_error(rsp_score_error),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         placements.check({rsp_pos_x, rsp_pos_y, rsp_placed, rsp_score,
                           rsp_score_valid, rsp_score_error});
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send_request(logic op, logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                               logic [INDEX_W-1:0] idx, logic last);
      req_op <= op;
      req_rect_width <= w;
      req_rect_height <= h;
      req_rect_index <= idx;
      req_last <= last;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      placements.note(op, w, h, idx, last);
      requests_sent++;
      if (last) orders_sent++;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (placements.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(logic idx, logic [WIN_W-1:0] value);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      placements.set_window(idx, value);
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(9))
         0: return '0;
         1: return SIZE_W'($urandom_range(0, 24'hFFFFFF));
         2: return '1;
         3: return SIZE_W'($urandom_range(1, 16));
         default: return SIZE_W'($urandom_range(1, 4096));
      endcase
   endfunction

   task automatic random_orders(int budget);
      int sent;
      int len;
      int newline_pct;
      sent = 0;
      while (sent < budget) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 10);
         newline_pct = ($urandom_range(11) == 0) ? 100 : $urandom_range(0, 35);
         for (int i = 0; i < len; i++) begin
            send_request(($urandom_range(99) < newline_pct) ? OP_NEWLINE : OP_PLACE,
                         pick_size(), pick_size(), INDEX_W'($urandom_range(0, 127)),
                         i == len - 1);
         end
         sent += len;
      end
   endtask

   task automatic directed_orders();
      send_request(OP_NEWLINE, '0, '0, '0, 1);
      send_request(OP_PLACE, '0, '0, 7'd127, 1);
      send_request(OP_PLACE, '0, 24'd5, 7'd127, 0);
      send_request(OP_PLACE, '0, '0, 7'd0, 1);
      send_request(OP_PLACE, 24'd0, 24'd0, 7'd0, 0);
      send_request(OP_PLACE, 24'd300, 24'd200, 7'd127, 1);
      send_request(OP_NEWLINE, '1, '1, 7'd127, 0);
      send_request(OP_PLACE, '1, '1, 7'd5, 0);
      send_request(OP_NEWLINE, '0, '0, '0, 0);
      send_request(OP_NEWLINE, '0, '0, '0, 0);
      send_request(OP_PLACE, 24'd256, 24'd256, 7'd9, 0);
      send_request(OP_NEWLINE, 24'h5A5A5A, 24'hA5A5A5, 7'd85, 1);
      send_request(OP_PLACE, 24'd512, 24'd1024, 7'd1, 0);
      send_request(OP_PLACE, 24'd256, 24'd512, 7'd2, 0);
      send_request(OP_PLACE, 24'd128, 24'd256, 7'd3, 0);
      send_request(OP_NEWLINE, '0, '0, '0, 0);
      send_request(OP_PLACE, 24'd1024, 24'd2048, 7'd4, 0);
      send_request(OP_NEWLINE, '0, '0, '0, 0);
      send_request(OP_PLACE, 24'd64, 24'd64, 7'd0, 1);
   endtask

   // descending steps until the corner list is full, then dropped rectangles
   task automatic fill_corners();
      for (int i = 0; i < 260; i++)
         send_request(OP_PLACE, 24'd256, SIZE_W'(4000 - 10 * i), INDEX_W'(i), i == 259);
   endtask

   task automatic saturate_row();
      for (int i = 0; i < 258; i++)
         send_request(OP_PLACE, '1, 24'd256, INDEX_W'(127 - i % 128), i == 257);
   endtask

   task automatic saturate_column();
      for (int i = 0; i < 258; i++) begin
         send_request(OP_PLACE, '1, '1, INDEX_W'(i), 0);
         send_request(OP_NEWLINE, '0, '0, '0, i == 257);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      directed_orders();
      random_orders(100);
      drain();

      write_window(REG_WINDOW_WIDTH, 16'd1);
      write_window(REG_WINDOW_HEIGHT, 16'd1);
      idle_pct = 73;
      fill_corners();
      random_orders(100);
      drain();

      write_window(REG_WINDOW_WIDTH, 16'hFFFF);
      write_window(REG_WINDOW_HEIGHT, 16'hFFFF);
      idle_pct = 0;
      stall_pct = 73;
      saturate_row();
      random_orders(100);
      drain();

      write_window(REG_WINDOW_WIDTH, 16'd0);
      write_window(REG_WINDOW_HEIGHT, 16'd480);
      idle_pct = 8;
      stall_pct = 8;
      random_orders(100);
      drain();

      write_window(REG_WINDOW_WIDTH, 16'hFFFF);
      write_window(REG_WINDOW_HEIGHT, 16'd1);
      idle_pct = 0;
      stall_pct = 0;
      saturate_column();
      random_orders(100);
      drain();

      write_window(REG_WINDOW_WIDTH, WIN_W'($urandom_range(1, 65535)));
      write_window(REG_WINDOW_HEIGHT, WIN_W'($urandom_range(1, 65535)));
      idle_pct = 73;
      stall_pct = 73;
      random_orders(100);
      drain();

      $display("Covered %0d requests in %0d orders, %0d responses checked,", requests_sent,
               orders_sent, placements.responses);
      $display("over six window settings incl. full corner list and coordinate saturation.");
      if (placements.errors == 0 && placements.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
